// ===== rtl/core/grc_pkg.sv =====
// Shared constants, types and helpers of the grid ray caster.
`timescale 1ns / 1ps
`default_nettype none
package grc_pkg;
  localparam int MAP_SIDE      = 8;
  localparam int CELL_W        = 3;
  localparam int ADDR_W        = 2 * CELL_W;
  localparam int MAP_DEPTH     = MAP_SIDE * MAP_SIDE;
  localparam int WALL_W        = 2;
  localparam int POS_W         = 15;
  localparam int FRAC_W        = 12;
  localparam int DIR_W         = 16;
  localparam int DIST_W        = 20;
  localparam int ROW_W         = 9;
  localparam int SCREEN_HEIGHT = 480;
  localparam int HALF_H        = SCREEN_HEIGHT / 2;
  localparam int DELTA_W       = 25;
  localparam int SIDE_W        = 46;
  localparam int INF_SHIFT     = 40;
  localparam int COORD_W       = CELL_W + 2;
  localparam int LOOP_N        = 2 * MAP_SIDE + 2;
  localparam int LOOP_W        = 5;
  localparam int DVD_W         = 25;
  localparam int DVS_W         = 20;
  localparam int CNT_W         = 5;
  localparam int LH_W          = 21;

  localparam logic OP_WRITE = 1'b0;
  localparam logic OP_CAST  = 1'b1;
  localparam logic REG_VIEWER_X = 1'b0;
  localparam logic REG_VIEWER_Y = 1'b1;

  localparam logic [DIST_W-1:0] DIST_MAX = {DIST_W{1'b1}};
  localparam logic [DVD_W-1:0] RECIP_DIVIDEND  = DVD_W'(1) << 24;
  localparam logic [DVD_W-1:0] HEIGHT_DIVIDEND = DVD_W'(SCREEN_HEIGHT) << FRAC_W;

  typedef struct packed {
    logic                    is_cast;
    logic signed [DIR_W-1:0] ray_dir_x;
    logic signed [DIR_W-1:0] ray_dir_y;
    logic [CELL_W-1:0]       cell_x;
    logic [CELL_W-1:0]       cell_y;
    logic [WALL_W-1:0]       cell_value;
  } cmd_t;

  typedef struct packed {
    logic [WALL_W-1:0] wall_value;
    logic              hit_side;
    logic [DIST_W-1:0] distance;
    logic [ROW_W-1:0]  span_start;
    logic [ROW_W-1:0]  span_end;
    logic              escaped;
  } res_t;

  typedef struct packed {
    logic             start;
    logic [DVD_W-1:0] dividend;
    logic [DVS_W-1:0] divisor;
  } div_req_t;

  typedef struct packed {
    logic             done;
    logic [DVD_W-1:0] quotient;
  } div_rsp_t;

  typedef enum logic [3:0] {
    ST_IDLE, ST_DIV_X, ST_DIV_Y, ST_INIT, ST_STEP, ST_TEST, ST_DIV_H, ST_SPAN, ST_FIN
  } back_state_t;

  function automatic logic [DIR_W-1:0] abs_dir(input logic signed [DIR_W-1:0] d);
    abs_dir = d[DIR_W-1] ? (~d + DIR_W'(1)) : d;
  endfunction
endpackage
`default_nettype wire

// ===== rtl/core/grc_if.sv =====
// Valid/ready channel interfaces for commands and results.
`timescale 1ns / 1ps
`default_nettype none
interface grc_in_if;
  logic                            valid;
  logic                            ready;
  logic                            opcode;
  logic signed [grc_pkg::DIR_W-1:0] ray_dir_x;
  logic signed [grc_pkg::DIR_W-1:0] ray_dir_y;
  logic [grc_pkg::CELL_W-1:0]       cell_x;
  logic [grc_pkg::CELL_W-1:0]       cell_y;
  logic [grc_pkg::WALL_W-1:0]       cell_value;
  modport source(output valid, opcode, ray_dir_x, ray_dir_y, cell_x, cell_y, cell_value,
                 input ready);
  modport sink(input valid, opcode, ray_dir_x, ray_dir_y, cell_x, cell_y, cell_value,
               output ready);
endinterface

interface grc_out_if;
  logic                       valid;
  logic                       ready;
  logic [grc_pkg::WALL_W-1:0] wall_value;
  logic                       hit_side;
  logic [grc_pkg::DIST_W-1:0] distance;
  logic [grc_pkg::ROW_W-1:0]  span_start;
  logic [grc_pkg::ROW_W-1:0]  span_end;
  logic                       escaped;
  modport source(output valid, wall_value, hit_side, distance, span_start, span_end, escaped,
                 input ready);
  modport sink(input valid, wall_value, hit_side, distance, span_start, span_end, escaped,
               output ready);
endinterface
`default_nettype wire

// ===== rtl/core/grc_front.sv =====
// Command intake: decodes transactions into a two-entry queue.
`timescale 1ns / 1ps
`default_nettype none
module grc_front (
  input  wire logic           clk,
  input  wire logic           rst,
  grc_in_if.sink              cmd_ch,
  output grc_pkg::cmd_t       head,
  output logic                head_valid,
  input  wire logic           pop
);
  grc_pkg::cmd_t q [2];
  logic       wr_ptr;
  logic       rd_ptr;
  logic [1:0] count;
  logic       push;

  assign cmd_ch.ready = (count != 2'd2);
  assign push         = cmd_ch.valid && cmd_ch.ready;
  assign head_valid   = (count != 2'd0);
  assign head         = q[rd_ptr];

  always_ff @(posedge clk) begin
    if (push) begin
      q[wr_ptr] <= '{is_cast:    (cmd_ch.opcode == grc_pkg::OP_CAST),
                     ray_dir_x:  cmd_ch.ray_dir_x,
                     ray_dir_y:  cmd_ch.ray_dir_y,
                     cell_x:     cmd_ch.cell_x,
                     cell_y:     cmd_ch.cell_y,
                     cell_value: cmd_ch.cell_value};
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= 1'b0;
      rd_ptr <= 1'b0;
      count  <= 2'd0;
    end else begin
      if (push) wr_ptr <= ~wr_ptr;
      if (pop) rd_ptr <= ~rd_ptr;
      count <= count + 2'(push) - 2'(pop);
    end
  end
endmodule
`default_nettype wire

// ===== rtl/core/grc_divider.sv =====
// Restoring divider, one quotient bit per cycle.
`timescale 1ns / 1ps
`default_nettype none
module grc_divider (
  input  wire logic          clk,
  input  wire logic          rst,
  input  grc_pkg::div_req_t  req,
  output grc_pkg::div_rsp_t  rsp
);
  logic [grc_pkg::DVS_W-1:0] rem;
  logic [grc_pkg::DVD_W-1:0] quo;
  logic [grc_pkg::DVS_W-1:0] dvs;
  logic [grc_pkg::CNT_W-1:0] cnt;
  logic                      busy;
  logic                      done;
  logic [grc_pkg::DVS_W:0]   trial;
  logic                      fits;

  assign trial = {rem, quo[grc_pkg::DVD_W-1]};
  assign fits  = (trial >= {1'b0, dvs});
  assign rsp.done     = done;
  assign rsp.quotient = quo;

  always_ff @(posedge clk) begin
    if (req.start && !busy) begin
      rem <= '0;
      quo <= req.dividend;
      dvs <= req.divisor;
    end else if (busy) begin
      rem <= fits ? grc_pkg::DVS_W'(trial - {1'b0, dvs}) : trial[grc_pkg::DVS_W-1:0];
      quo <= {quo[grc_pkg::DVD_W-2:0], fits};
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
      cnt  <= '0;
    end else begin
      done <= 1'b0;
      if (req.start && !busy) begin
        busy <= 1'b1;
        cnt  <= grc_pkg::CNT_W'(grc_pkg::DVD_W);
      end else if (busy) begin
        cnt <= cnt - grc_pkg::CNT_W'(1);
        if (cnt == grc_pkg::CNT_W'(1)) begin
          busy <= 1'b0;
          done <= 1'b1;
        end
      end
    end
  end
endmodule
`default_nettype wire

// ===== rtl/core/grc_back.sv =====
// Command execution: map store, DDA walk, span computation, result register.
`timescale 1ns / 1ps
`default_nettype none
module grc_back (
  input  wire logic                        clk,
  input  wire logic                        rst,
  input  grc_pkg::cmd_t                    head,
  input  wire logic                        head_valid,
  output logic                             pop,
  input  wire logic [grc_pkg::POS_W-1:0]   viewer_x,
  input  wire logic [grc_pkg::POS_W-1:0]   viewer_y,
  output grc_pkg::div_req_t                div_req,
  input  grc_pkg::div_rsp_t                div_rsp,
  output grc_pkg::res_t                    res,
  output logic                             res_valid,
  input  wire logic                        res_ready
);
  localparam grc_pkg::res_t ESC_RES = '{wall_value: '0, hit_side: 1'b0, distance: '0,
                                        span_start: '0, span_end: '0, escaped: 1'b1};

  grc_pkg::back_state_t state, state_next;
  grc_pkg::cmd_t cur, cur_next;
  grc_pkg::res_t pend, pend_next;
  logic [grc_pkg::DELTA_W-1:0] ddx, ddx_next, ddy, ddy_next;
  logic [grc_pkg::SIDE_W-1:0]  distx, distx_next, disty, disty_next, perp, perp_next;
  logic signed [grc_pkg::COORD_W-1:0] cx, cx_next, cy, cy_next;
  logic                        side, side_next;
  logic [grc_pkg::LOOP_W-1:0]  n, n_next;
  logic [grc_pkg::LH_W-1:0]    lh, lh_next;

  logic [grc_pkg::WALL_W-1:0] mem [grc_pkg::MAP_DEPTH];
  logic [grc_pkg::MAP_DEPTH-1:0] vld;
  logic [grc_pkg::WALL_W-1:0] rd_data;
  logic                       rd_vld;
  logic [grc_pkg::ADDR_W-1:0] rd_addr;
  logic                       map_we;

  logic                       infx, infy, step_x, in_map, load;
  logic [grc_pkg::SIDE_W-1:0] ddx_full, ddy_full;
  logic [grc_pkg::FRAC_W:0]   fsel_x, fsel_y;
  logic [grc_pkg::FRAC_W-1:0] fx, fy;
  logic [grc_pkg::FRAC_W+grc_pkg::DELTA_W:0] prod_x, prod_y;
  logic [grc_pkg::DIST_W-1:0] dist_sat;
  logic [grc_pkg::LH_W-2:0]   half;
  logic signed [grc_pkg::COORD_W-1:0] cx_step, cy_step;

  assign infx     = (cur.ray_dir_x == '0);
  assign infy     = (cur.ray_dir_y == '0);
  assign ddx_full = infx ? (grc_pkg::SIDE_W'(1) << grc_pkg::INF_SHIFT) : grc_pkg::SIDE_W'(ddx);
  assign ddy_full = infy ? (grc_pkg::SIDE_W'(1) << grc_pkg::INF_SHIFT) : grc_pkg::SIDE_W'(ddy);
  assign fx       = viewer_x[grc_pkg::FRAC_W-1:0];
  assign fy       = viewer_y[grc_pkg::FRAC_W-1:0];
  assign fsel_x   = cur.ray_dir_x[grc_pkg::DIR_W-1] ? {1'b0, fx}
                                                   : (grc_pkg::FRAC_W+1)'(4096) - {1'b0, fx};
  assign fsel_y   = cur.ray_dir_y[grc_pkg::DIR_W-1] ? {1'b0, fy}
                                                   : (grc_pkg::FRAC_W+1)'(4096) - {1'b0, fy};
  assign prod_x   = fsel_x * ddx;
  assign prod_y   = fsel_y * ddy;
  assign step_x   = (distx < disty);
  assign cx_step  = !step_x ? cx : (cur.ray_dir_x[grc_pkg::DIR_W-1] ? cx - grc_pkg::COORD_W'(1)
                                                                   : cx + grc_pkg::COORD_W'(1));
  assign cy_step  = step_x ? cy : (cur.ray_dir_y[grc_pkg::DIR_W-1] ? cy - grc_pkg::COORD_W'(1)
                                                                  : cy + grc_pkg::COORD_W'(1));
  assign rd_addr  = {cx_step[grc_pkg::CELL_W-1:0], cy_step[grc_pkg::CELL_W-1:0]};
  assign in_map   = (cx[grc_pkg::COORD_W-1:grc_pkg::CELL_W] == '0)
                 && (cy[grc_pkg::COORD_W-1:grc_pkg::CELL_W] == '0);
  assign dist_sat = (perp > grc_pkg::SIDE_W'(grc_pkg::DIST_MAX)) ? grc_pkg::DIST_MAX
                                                              : perp[grc_pkg::DIST_W-1:0];
  assign half     = lh[grc_pkg::LH_W-1:1];
  assign load     = (state == grc_pkg::ST_FIN) && (!res_valid || res_ready);

  always_ff @(posedge clk) begin
    if (map_we) mem[{head.cell_x, head.cell_y}] <= head.cell_value;
    rd_data <= mem[rd_addr];
    rd_vld  <= vld[rd_addr];
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      vld <= '0;
    end else if (map_we) begin
      vld[{head.cell_x, head.cell_y}] <= 1'b1;
    end
  end

  always_comb begin
    state_next = state;
    cur_next   = cur;
    pend_next  = pend;
    ddx_next   = ddx;
    ddy_next   = ddy;
    distx_next = distx;
    disty_next = disty;
    perp_next  = perp;
    cx_next    = cx;
    cy_next    = cy;
    side_next  = side;
    n_next     = n;
    lh_next    = lh;
    pop        = 1'b0;
    map_we     = 1'b0;
    div_req    = '{start: 1'b0, dividend: grc_pkg::RECIP_DIVIDEND,
                   divisor: grc_pkg::DVS_W'(grc_pkg::abs_dir(head.ray_dir_x))};
    unique case (state)
      grc_pkg::ST_IDLE: begin
        if (head_valid) begin
          pop      = 1'b1;
          cur_next = head;
          if (head.is_cast) begin
            div_req.start = 1'b1;
            state_next    = grc_pkg::ST_DIV_X;
          end else begin
            map_we     = 1'b1;
            pend_next  = '0;
            state_next = grc_pkg::ST_FIN;
          end
        end
      end
      grc_pkg::ST_DIV_X: begin
        div_req.divisor = grc_pkg::DVS_W'(grc_pkg::abs_dir(cur.ray_dir_y));
        if (div_rsp.done) begin
          ddx_next      = div_rsp.quotient;
          div_req.start = 1'b1;
          state_next    = grc_pkg::ST_DIV_Y;
        end
      end
      grc_pkg::ST_DIV_Y: begin
        if (div_rsp.done) begin
          ddy_next   = div_rsp.quotient;
          state_next = grc_pkg::ST_INIT;
        end
      end
      grc_pkg::ST_INIT: begin
        distx_next = infx ? (grc_pkg::SIDE_W'(fsel_x) << 28)
                          : grc_pkg::SIDE_W'(prod_x[grc_pkg::FRAC_W+grc_pkg::DELTA_W:
                                                    grc_pkg::FRAC_W]);
        disty_next = infy ? (grc_pkg::SIDE_W'(fsel_y) << 28)
                          : grc_pkg::SIDE_W'(prod_y[grc_pkg::FRAC_W+grc_pkg::DELTA_W:
                                                    grc_pkg::FRAC_W]);
        cx_next    = grc_pkg::COORD_W'(viewer_x[grc_pkg::POS_W-1:grc_pkg::FRAC_W]);
        cy_next    = grc_pkg::COORD_W'(viewer_y[grc_pkg::POS_W-1:grc_pkg::FRAC_W]);
        n_next     = '0;
        state_next = grc_pkg::ST_STEP;
      end
      grc_pkg::ST_STEP: begin
        cx_next = cx_step;
        cy_next = cy_step;
        if (step_x) begin
          perp_next  = distx;
          distx_next = distx + ddx_full;
          side_next  = 1'b0;
        end else begin
          perp_next  = disty;
          disty_next = disty + ddy_full;
          side_next  = 1'b1;
        end
        state_next = grc_pkg::ST_TEST;
      end
      grc_pkg::ST_TEST: begin
        if (!in_map) begin
          pend_next  = ESC_RES;
          state_next = grc_pkg::ST_FIN;
        end else if (rd_vld && (rd_data != '0)) begin
          pend_next = '{wall_value: rd_data, hit_side: side, distance: dist_sat,
                        span_start: '0, span_end: '0, escaped: 1'b0};
          if (dist_sat == '0) begin
            lh_next    = grc_pkg::LH_W'(grc_pkg::SCREEN_HEIGHT);
            state_next = grc_pkg::ST_SPAN;
          end else begin
            div_req.start    = 1'b1;
            div_req.dividend = grc_pkg::HEIGHT_DIVIDEND;
            div_req.divisor  = dist_sat;
            state_next       = grc_pkg::ST_DIV_H;
          end
        end else if (n == grc_pkg::LOOP_W'(grc_pkg::LOOP_N - 1)) begin
          pend_next  = ESC_RES;
          state_next = grc_pkg::ST_FIN;
        end else begin
          n_next     = n + grc_pkg::LOOP_W'(1);
          state_next = grc_pkg::ST_STEP;
        end
      end
      grc_pkg::ST_DIV_H: begin
        if (div_rsp.done) begin
          lh_next    = div_rsp.quotient[grc_pkg::LH_W-1:0];
          state_next = grc_pkg::ST_SPAN;
        end
      end
      grc_pkg::ST_SPAN: begin
        if (half >= (grc_pkg::LH_W-1)'(grc_pkg::HALF_H)) begin
          pend_next.span_start = '0;
          pend_next.span_end   = grc_pkg::ROW_W'(grc_pkg::SCREEN_HEIGHT - 1);
        end else begin
          pend_next.span_start = grc_pkg::ROW_W'(grc_pkg::HALF_H - int'(half));
          pend_next.span_end   = grc_pkg::ROW_W'(grc_pkg::HALF_H + int'(half));
        end
        state_next = grc_pkg::ST_FIN;
      end
      grc_pkg::ST_FIN: begin
        if (load) state_next = grc_pkg::ST_IDLE;
      end
      default: state_next = grc_pkg::ST_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) state <= grc_pkg::ST_IDLE;
    else     state <= state_next;
  end

  always_ff @(posedge clk) begin
    cur   <= cur_next;
    pend  <= pend_next;
    ddx   <= ddx_next;
    ddy   <= ddy_next;
    distx <= distx_next;
    disty <= disty_next;
    perp  <= perp_next;
    cx    <= cx_next;
    cy    <= cy_next;
    side  <= side_next;
    n     <= n_next;
    lh    <= lh_next;
    if (load) res <= pend;
  end

  always_ff @(posedge clk) begin
    if (rst)                  res_valid <= 1'b0;
    else if (load)            res_valid <= 1'b1;
    else if (res_ready)       res_valid <= 1'b0;
  end
endmodule
`default_nettype wire

// ===== rtl/core/grid_ray_caster.sv =====
// Top level of the grid ray caster: intake queue, divider and execution core.
//
// Usage: commands arrive on cmd_ch (valid/ready). Opcode write stores one
// 2-bit wall code in the 8x8 map; opcode cast walks a ray from the viewer
// position (cfg registers viewer_x, viewer_y) and reports the hit wall,
// hit side, perpendicular distance and the clamped screen span. Every
// transaction on cmd_ch yields exactly one transaction on res_ch, in order.
// A cast takes two reciprocal divisions, a setup state, a step state and
// a test state per grid step (up to 18 steps) and, on a hit, a height
// division. All divisions run on the shared serial divider, and the map
// read of each step is registered. One command is executed at a time.
// A two-entry queue keeps taking commands while one executes until it is full, and the
// result register holds a result while res_ch stalls; the core waits
// only when it has a new result and the register is still full.
// Reset (rst, synchronous) empties the queue and result register, marks
// every map cell empty at once and loads the default viewer position.
// Config writes are expected only while the block is idle.
`timescale 1ns / 1ps
`default_nettype none
module grid_ray_caster (
  input  wire logic                       clk,
  input  wire logic                       rst,
  grc_in_if.sink                          cmd_ch,
  grc_out_if.source                       res_ch,
  input  wire logic                       cfg_we,
  input  wire logic                       cfg_index,
  input  wire logic [grc_pkg::POS_W-1:0]  cfg_data
);
  grc_pkg::cmd_t     head;
  logic              head_valid;
  logic              pop;
  grc_pkg::div_req_t div_req;
  grc_pkg::div_rsp_t div_rsp;
  grc_pkg::res_t     res;
  logic              res_valid;
  logic [grc_pkg::POS_W-1:0] viewer_x;
  logic [grc_pkg::POS_W-1:0] viewer_y;

  always_ff @(posedge clk) begin
    if (rst) begin
      viewer_x <= grc_pkg::POS_W'(4096);
      viewer_y <= grc_pkg::POS_W'(8192);
    end else if (cfg_we) begin
      if (cfg_index == grc_pkg::REG_VIEWER_X) viewer_x <= cfg_data;
      if (cfg_index == grc_pkg::REG_VIEWER_Y) viewer_y <= cfg_data;
    end
  end

  grc_front u_front (
    .clk(clk), .rst(rst), .cmd_ch(cmd_ch),
    .head(head), .head_valid(head_valid), .pop(pop)
  );

  grc_divider u_div (.clk(clk), .rst(rst), .req(div_req), .rsp(div_rsp));

  grc_back u_back (
    .clk(clk), .rst(rst), .head(head), .head_valid(head_valid), .pop(pop),
    .viewer_x(viewer_x), .viewer_y(viewer_y),
    .div_req(div_req), .div_rsp(div_rsp),
    .res(res), .res_valid(res_valid), .res_ready(res_ch.ready)
  );

  assign res_ch.valid      = res_valid;
  assign res_ch.wall_value = res.wall_value;
  assign res_ch.hit_side   = res.hit_side;
  assign res_ch.distance   = res.distance;
  assign res_ch.span_start = res.span_start;
  assign res_ch.span_end   = res.span_end;
  assign res_ch.escaped    = res.escaped;
endmodule
`default_nettype wire

// ===== rtl/core/grc_checker.sv =====
// Port-level checks of the grid ray caster, bound to the top level.
`timescale 1ns / 1ps
`default_nettype none
module grc_checker (
  input wire logic                       clk,
  input wire logic                       rst,
  input wire logic                       valid,
  input wire logic                       ready,
  input wire logic [grc_pkg::WALL_W-1:0] wall_value,
  input wire logic                       hit_side,
  input wire logic [grc_pkg::DIST_W-1:0] distance,
  input wire logic [grc_pkg::ROW_W-1:0]  span_start,
  input wire logic [grc_pkg::ROW_W-1:0]  span_end,
  input wire logic                       escaped
);
  a_rst_quiet: assert property (@(posedge clk) rst |=> !valid)
    else $error("result valid right after reset");

  a_hold: assert property (@(posedge clk) disable iff (rst)
    valid && !ready |=> valid && $stable(distance) && $stable(wall_value) && $stable(escaped))
    else $error("stalled result changed");

  a_escape: assert property (@(posedge clk) disable iff (rst)
    valid && escaped |-> wall_value == '0 && distance == '0 && span_start == '0
                         && span_end == '0 && !hit_side)
    else $error("escape result not clean");

  a_write: assert property (@(posedge clk) disable iff (rst)
    valid && !escaped && wall_value == '0 |-> distance == '0 && span_start == '0
                                             && span_end == '0 && !hit_side)
    else $error("write result not zero");

  a_span: assert property (@(posedge clk) disable iff (rst)
    valid && wall_value != '0 |-> span_start <= span_end
                                  && span_end <= grc_pkg::ROW_W'(grc_pkg::SCREEN_HEIGHT - 1))
    else $error("span out of order");
endmodule

bind grid_ray_caster grc_checker u_grc_checker (
  .clk(clk), .rst(rst), .valid(res_ch.valid), .ready(res_ch.ready),
  .wall_value(res_ch.wall_value), .hit_side(res_ch.hit_side),
  .distance(res_ch.distance), .span_start(res_ch.span_start),
  .span_end(res_ch.span_end), .escaped(res_ch.escaped)
);
`default_nettype wire

// ===== test/tb_grid_ray_caster.sv =====
// Testbench for grid_ray_caster: directed table then random casts and writes, checked by a DDA predictor.
`timescale 1ns / 1ps
module tb_grid_ray_caster;
  localparam int CYCLE_LIMIT = 1500000;

  typedef struct {
    logic is_cast;
    logic signed [grc_pkg::DIR_W-1:0] dx;
    logic signed [grc_pkg::DIR_W-1:0] dy;
    logic [grc_pkg::CELL_W-1:0] cx;
    logic [grc_pkg::CELL_W-1:0] cy;
    logic [grc_pkg::WALL_W-1:0] val;
    bit typed;
    grc_pkg::res_t want;
  } stim_row_t;

  logic clk;
  logic rst;
  logic cfg_we;
  logic cfg_index;
  logic [grc_pkg::POS_W-1:0] cfg_data;

  grc_in_if cmd_ch();
  grc_out_if res_ch();

  grid_ray_caster dut (
    .clk(clk), .rst(rst), .cmd_ch(cmd_ch.sink), .res_ch(res_ch.source),
    .cfg_we(cfg_we), .cfg_index(cfg_index), .cfg_data(cfg_data)
  );

  logic [grc_pkg::WALL_W-1:0] map_model [grc_pkg::MAP_DEPTH];
  logic [grc_pkg::POS_W-1:0] pos_x, pos_y;
  grc_pkg::res_t pending_results[$];
  int errors;
  int cycles;
  bit calm;

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles > CYCLE_LIMIT) begin
      $display("FAIL");
      $finish;
    end
  end

  function automatic logic [63:0] step_len(logic signed [grc_pkg::DIR_W-1:0] d);
    logic [grc_pkg::DIR_W-1:0] m;
    if (d == 0) return 64'd1 << grc_pkg::INF_SHIFT;
    m = d[grc_pkg::DIR_W-1] ? -d : d;
    return (64'd1 << 24) / m;
  endfunction

  function automatic grc_pkg::res_t cast_predict(logic signed [grc_pkg::DIR_W-1:0] dx,
                                                 logic signed [grc_pkg::DIR_W-1:0] dy);
    grc_pkg::res_t r;
    logic [63:0] ddx, ddy, sdx, sdy, perp, lh;
    int cx, cy, sx, sy, n, st, en;
    logic side;
    logic [grc_pkg::WALL_W-1:0] w;
    r = '0;
    r.escaped = 1'b1;
    ddx = step_len(dx);
    ddy = step_len(dy);
    cx = pos_x >> grc_pkg::FRAC_W;
    cy = pos_y >> grc_pkg::FRAC_W;
    side = 1'b0;
    w = '0;
    if (cx >= grc_pkg::MAP_SIDE || cy >= grc_pkg::MAP_SIDE) return r;
    if (dx < 0) begin
      sx = -1; sdx = ((pos_x & 64'hFFF) * ddx) >> grc_pkg::FRAC_W;
    end else begin
      sx = 1; sdx = ((4096 - (pos_x & 64'hFFF)) * ddx) >> grc_pkg::FRAC_W;
    end
    if (dy < 0) begin
      sy = -1; sdy = ((pos_y & 64'hFFF) * ddy) >> grc_pkg::FRAC_W;
    end else begin
      sy = 1; sdy = ((4096 - (pos_y & 64'hFFF)) * ddy) >> grc_pkg::FRAC_W;
    end
    for (n = 0; n < grc_pkg::LOOP_N; n++) begin
      if (sdx < sdy) begin
        sdx += ddx; cx += sx; side = 1'b0;
      end else begin
        sdy += ddy; cy += sy; side = 1'b1;
      end
      if (cx < 0 || cx >= grc_pkg::MAP_SIDE || cy < 0 || cy >= grc_pkg::MAP_SIDE) return r;
      w = map_model[cx * grc_pkg::MAP_SIDE + cy];
      if (w != 0) break;
    end
    if (w == 0) return r;
    perp = side ? sdy - ddy : sdx - ddx;
    if (perp > grc_pkg::DIST_MAX) perp = grc_pkg::DIST_MAX;
    lh = (perp == 0) ? grc_pkg::SCREEN_HEIGHT
                     : ((64'(grc_pkg::SCREEN_HEIGHT) << grc_pkg::FRAC_W) / perp);
    st = grc_pkg::HALF_H - int'(lh / 2);
    if (st < 0) st = 0;
    en = grc_pkg::HALF_H + int'(lh / 2);
    if (en >= grc_pkg::SCREEN_HEIGHT) en = grc_pkg::SCREEN_HEIGHT - 1;
    r.wall_value = w;
    r.hit_side = side;
    r.distance = perp[grc_pkg::DIST_W-1:0];
    r.span_start = st[grc_pkg::ROW_W-1:0];
    r.span_end = en[grc_pkg::ROW_W-1:0];
    r.escaped = 1'b0;
    return r;
  endfunction

  // Send one transaction; the predictor runs at acceptance.
  task automatic send_cmd(stim_row_t s, bit gaps);
    grc_pkg::res_t r;
    while (gaps && $urandom_range(99) < 28) begin
      cmd_ch.valid <= 1'b0;
      @(negedge clk);
    end
    cmd_ch.valid <= 1'b1;
    cmd_ch.opcode <= s.is_cast ? grc_pkg::OP_CAST : grc_pkg::OP_WRITE;
    cmd_ch.ray_dir_x <= s.dx;
    cmd_ch.ray_dir_y <= s.dy;
    cmd_ch.cell_x <= s.cx;
    cmd_ch.cell_y <= s.cy;
    cmd_ch.cell_value <= s.val;
    @(posedge clk);
    while (!cmd_ch.ready) @(posedge clk);
    if (s.is_cast) r = cast_predict(s.dx, s.dy);
    else begin
      map_model[s.cx * grc_pkg::MAP_SIDE + s.cy] = s.val;
      r = '0;
    end
    if (s.typed && r != s.want) begin
      $display("%0t table mismatch: expected %h, actual %h", $time, s.want, r);
      errors++;
    end
    pending_results.push_back(s.typed ? s.want : r);
    @(negedge clk);
  endtask

  always @(negedge clk) begin
    if (!rst) res_ch.ready <= calm ? 1'b1 : ($urandom_range(99) >= 28);
  end

  always @(posedge clk) begin
    grc_pkg::res_t got, want;
    if (!rst && res_ch.valid && res_ch.ready) begin
      got = '{res_ch.wall_value, res_ch.hit_side, res_ch.distance,
              res_ch.span_start, res_ch.span_end, res_ch.escaped};
      if (pending_results.size() == 0) begin
        $display("%0t unexpected transaction: actual %h", $time, got);
        errors++;
      end else begin
        want = pending_results.pop_front();
        if (got.wall_value != want.wall_value || got.hit_side != want.hit_side ||
            got.distance != want.distance || got.span_start != want.span_start ||
            got.span_end != want.span_end || got.escaped != want.escaped) begin
          $display("%0t mismatch: expected %h, actual %h", $time, want, got);
          errors++;
        end
      end
    end
  end

  task automatic drain();
    cmd_ch.valid <= 1'b0;
    while (pending_results.size() != 0) @(negedge clk);
    repeat (130) @(negedge clk);
  endtask

  task automatic set_viewer(logic [grc_pkg::POS_W-1:0] vx, logic [grc_pkg::POS_W-1:0] vy);
    cfg_we <= 1'b1;
    cfg_index <= grc_pkg::REG_VIEWER_X;
    cfg_data <= vx;
    @(negedge clk);
    cfg_index <= grc_pkg::REG_VIEWER_Y;
    cfg_data <= vy;
    @(negedge clk);
    cfg_we <= 1'b0;
    pos_x = vx;
    pos_y = vy;
  endtask

  function automatic stim_row_t wr(int x, int y, int v);
    stim_row_t s;
    s = '{1'b0, '0, '0, x[grc_pkg::CELL_W-1:0], y[grc_pkg::CELL_W-1:0],
          v[grc_pkg::WALL_W-1:0], 1'b1, grc_pkg::res_t'('0)};
    return s;
  endfunction

  function automatic stim_row_t ray(int dx, int dy, bit esc_known);
    stim_row_t s;
    grc_pkg::res_t e;
    e = '0;
    e.escaped = 1'b1;
    s = '{1'b1, dx[grc_pkg::DIR_W-1:0], dy[grc_pkg::DIR_W-1:0], '0, '0, '0, esc_known, e};
    return s;
  endfunction

  function automatic stim_row_t rand_row();
    stim_row_t s;
    int k;
    s = ray($urandom, $urandom, 1'b0);
    k = $urandom_range(9);
    if (k < 3) s = wr($urandom_range(7), $urandom_range(7), $urandom_range(3));
    else if (k < 5) begin
      s.dx = $urandom_range(8192) - 4096;
      s.dy = $urandom_range(8192) - 4096;
    end else if (k == 5) begin
      s.dx = (k & $urandom_range(1)) ? 0 : s.dx;
      s.dy = $urandom_range(1) ? 0 : s.dy;
    end
    return s;
  endfunction

  stim_row_t table_rows[$];

  initial begin
    int i, ph;
    stim_row_t s;
    errors = 0;
    cycles = 0;
    calm = 1'b0;
    rst = 1'b1;
    cfg_we = 1'b0;
    cfg_index = grc_pkg::REG_VIEWER_X;
    cfg_data = '0;
    cmd_ch.valid = 1'b0;
    cmd_ch.opcode = grc_pkg::OP_WRITE;
    cmd_ch.ray_dir_x = '0;
    cmd_ch.ray_dir_y = '0;
    cmd_ch.cell_x = '0;
    cmd_ch.cell_y = '0;
    cmd_ch.cell_value = '0;
    res_ch.ready = 1'b0;
    for (i = 0; i < grc_pkg::MAP_DEPTH; i++) map_model[i] = '0;
    pos_x = 4096;
    pos_y = 8192;
    repeat (6) @(negedge clk);
    rst = 1'b0;

    // empty map after reset: every ray escapes
    table_rows.push_back(ray(4096, 0, 1'b1));
    table_rows.push_back(ray(0, 0, 1'b1));
    table_rows.push_back(ray(-32768, 32767, 1'b1));
    table_rows.push_back(wr(7, 7, 3));
    table_rows.push_back(wr(0, 0, 1));
    table_rows.push_back(wr(1, 2, 2));
    table_rows.push_back(wr(3, 2, 1));
    table_rows.push_back(wr(1, 5, 3));
    table_rows.push_back(ray(4096, 0, 1'b0));
    table_rows.push_back(ray(-4096, 0, 1'b0));
    table_rows.push_back(ray(0, 4096, 1'b0));
    table_rows.push_back(ray(0, -32768, 1'b0));
    table_rows.push_back(ray(32767, 32767, 1'b0));
    table_rows.push_back(ray(-1, 1, 1'b0));
    table_rows.push_back(ray(1, -1, 1'b0));
    table_rows.push_back(ray(0, 0, 1'b0));
    table_rows.push_back(wr(2, 2, 0));
    table_rows.push_back(ray(-32768, -32768, 1'b0));
    foreach (table_rows[i]) send_cmd(table_rows[i], 1'b0);
    drain();

    // viewer at the far corner inside a wall, then at the origin
    set_viewer(15'h7FFF, 15'h7FFF);
    send_cmd(ray(-4096, -4096, 1'b0), 1'b0);
    drain();
    set_viewer(15'h0000, 15'h0000);
    send_cmd(ray(4096, 4096, 1'b0), 1'b0);
    send_cmd(ray(0, 0, 1'b0), 1'b0);
    drain();

    for (ph = 0; ph < 6; ph++) begin
      calm = (ph == 2);
      if (ph == 5) set_viewer($urandom, $urandom);
      else set_viewer($urandom_range(32767), $urandom_range(32767));
      if (ph < 5) set_viewer(15'($urandom_range(7) * 4096 + $urandom_range(4095)),
                             15'($urandom_range(7) * 4096 + $urandom_range(4095)));
      for (i = 0; i < 320; i++) begin
        s = rand_row();
        send_cmd(s, !calm);
      end
      drain();
    end
    calm = 1'b0;

    if (errors == 0) begin
      $display("PASS");
    end else begin
      $display("FAIL");
    end
    $finish;
  end
endmodule

// ===== files.f =====
rtl/core/grc_pkg.sv
rtl/core/grc_if.sv
rtl/core/grc_front.sv
rtl/core/grc_divider.sv
rtl/core/grc_back.sv
rtl/core/grid_ray_caster.sv
rtl/core/grc_checker.sv
test/tb_grid_ray_caster.sv
